@@ hdl/rgbn_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB frame node package
// Shared widths, frame constants and the result word type of the frame node.
// ----------------------------------------------------------------------------
package rgbn_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = BYTE_W + 1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;

	// Frames at least this long are forwarded down the chain.
	localparam byte_t FWD_MIN_LEN = byte_t'(8);
	// Each node strips its own red, green and blue bytes from the forwarded length.
	localparam byte_t LEN_ADJUST  = byte_t'(3);

	// Byte positions inside a frame that carry the color levels.
	localparam pos_t POS_RED   = pos_t'(1);
	localparam pos_t POS_GREEN = pos_t'(2);
	localparam pos_t POS_BLUE  = pos_t'(3);

	// One result word.
	typedef struct packed {
		logic  tx_valid;
		byte_t tx_byte;
		byte_t red_duty;
		byte_t green_duty;
		byte_t blue_duty;
	} result_t;

endpackage

@@ hdl/daisy_chain_rgb_frame_node_top.sv @@
// ----------------------------------------------------------------------------
// Daisy-chain RGB frame node
// Consumes received frame bytes, sets RGB duty levels and forwards the rest.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, rx_byte) takes one received byte per
// word. The output channel (out_valid, out_stall and the result fields) gives
// exactly one word per input byte: tx_valid and tx_byte tell whether a byte is
// to be sent downstream, and the three duty fields show the color levels after
// that byte.
// A byte passes an input register and then the frame decode, whose result is
// caught in the output register. One byte is taken every cycle while the
// receiver keeps out_stall low; the rate is set by the single decode step
// between the two registers, which also updates the frame count and levels.
// When the receiver stalls, the output word holds, the input register fills
// and in_stall rises until the output word is taken.
// Reset clears the frame count, frame length, color levels and both valid
// flags; the first byte after reset is read as a frame length.
// ----------------------------------------------------------------------------
module daisy_chain_rgb_frame_node_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rgbn_pkg::byte_t rx_byte,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            tx_valid,
	output rgbn_pkg::byte_t tx_byte,
	output rgbn_pkg::byte_t red_duty,
	output rgbn_pkg::byte_t green_duty,
	output rgbn_pkg::byte_t blue_duty
);
	import rgbn_pkg::*;

	logic    valid_s1;
	byte_t   byte_s1;
	logic    take;
	logic    fire;
	result_t result;
	result_t result_q;
	logic    out_valid_q;

	// The output register can load when empty or being read.
	assign take = !out_valid_q || !out_stall;
	assign fire = valid_s1 && take;

	rgbn_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rgbn_frame_core u_frame_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign tx_valid   = result_q.tx_valid;
	assign tx_byte    = result_q.tx_byte;
	assign red_duty   = result_q.red_duty;
	assign green_duty = result_q.green_duty;
	assign blue_duty  = result_q.blue_duty;

endmodule

@@ hdl/rgbn_in_stage.sv @@
// ----------------------------------------------------------------------------
// RGB frame node input stage
// Registers the incoming byte and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rgbn_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rgbn_pkg::byte_t rx_byte,
	input  logic          take,
	output logic          valid_s1,
	output rgbn_pkg::byte_t byte_s1
);
	import rgbn_pkg::*;

	logic load;

	// The stage can load when it is empty or its word moves on this cycle.
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Byte register.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

@@ hdl/rgbn_frame_core.sv @@
// ----------------------------------------------------------------------------
// RGB frame node core
// Tracks the frame position, updates the color levels and decides forwarding.
// ----------------------------------------------------------------------------
module rgbn_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rgbn_pkg::byte_t   byte_s1,
	output rgbn_pkg::result_t result
);
	import rgbn_pkg::*;

	byte_t bytes_left_q;
	byte_t frame_length_q;
	byte_t red_q;
	byte_t green_q;
	byte_t blue_q;

	byte_t bytes_left_d;
	byte_t frame_length_d;
	byte_t red_d;
	byte_t green_d;
	byte_t blue_d;
	pos_t  pos;

	// Position in the frame as a signed difference; negative values never match.
	assign pos = {1'b0, frame_length_q} - {1'b0, bytes_left_q};

	// Decode one byte against the current frame state.
	always_comb begin
		frame_length_d   = frame_length_q;
		red_d            = red_q;
		green_d          = green_q;
		blue_d           = blue_q;
		result.tx_valid  = 1'b0;
		result.tx_byte   = '0;
		bytes_left_d     = bytes_left_q - byte_t'(1);
		if (bytes_left_q == '0) begin
			// A new frame starts with its length byte.
			frame_length_d = byte_s1;
			bytes_left_d   = byte_s1 - byte_t'(1);
			if (byte_s1 >= FWD_MIN_LEN) begin
				result.tx_valid = 1'b1;
				result.tx_byte  = byte_s1 - LEN_ADJUST;
			end
		end else if (pos == POS_RED) begin
			red_d = byte_s1;
		end else if (pos == POS_GREEN) begin
			green_d = byte_s1;
		end else if (pos == POS_BLUE) begin
			blue_d = byte_s1;
		end else if (frame_length_q >= FWD_MIN_LEN) begin
			result.tx_valid = 1'b1;
			result.tx_byte  = byte_s1;
		end
		result.red_duty   = red_d;
		result.green_duty = green_d;
		result.blue_duty  = blue_d;
	end

	// Frame state and color levels advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q   <= '0;
			frame_length_q <= '0;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
		end else if (fire) begin
			bytes_left_q   <= bytes_left_d;
			frame_length_q <= frame_length_d;
			red_q          <= red_d;
			green_q        <= green_d;
			blue_q         <= blue_d;
		end
	end

endmodule
